>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

>>> src/ehi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ehi_pkg;

   localparam int MAX_DEPTH        = 6;
   localparam int DIR_SIZE         = 1 << MAX_DEPTH;
   localparam int DIR_W            = MAX_DEPTH;
   localparam int DEPTH_W          = $clog2(MAX_DEPTH + 1);
   localparam int DJ_W             = DEPTH_W + 1;
   localparam int POS_W            = $clog2(MAX_DEPTH);
   localparam int USED_W           = $clog2(DIR_SIZE + 1);
   localparam int KEY_WIDTH        = 31;
   localparam int HB_W             = 5;
   localparam int BUCKET_SLOTS_DEF = 4;
   localparam int REQ_W            = ((KEY_WIDTH + 7) / 8) * 8;
   localparam int RSP_W            = 16;

   localparam logic [HB_W-1:0] HB_RESET = HB_W'(6);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIR_RD,
      ST_INFO_RD,
      ST_DECIDE,
      ST_KEY_ADDR,
      ST_KEY_DATA,
      ST_SCAN,
      ST_SPLIT_DIR,
      ST_SPLIT_INFO,
      ST_FINAL_INFO,
      ST_KEY_WR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic info_rd;
      logic decide;
      logic key_cap;
      logic scan;
      logic split_dir;
      logic split_info;
      logic final_info;
      logic key_wr;
      logic result_ld;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic fill_full;
      logic fill_append;
      logic keys_done;
      logic scan_ovf;
      logic scan_hit;
      logic dir_done;
      logic split_last;
      logic wr_done;
      logic rsp_free;
   } status_type;

   // hash placed at the top of a full-depth directory index
   function automatic logic [DIR_W-1:0] full_hash(input logic [KEY_WIDTH-1:0] key,
                                                  input logic [HB_W-1:0] hb);
      logic [KEY_WIDTH-1:0]       h;
      logic [KEY_WIDTH+DIR_W-1:0] wide;
      for (int i = 0; i < KEY_WIDTH; i++) begin
         h[i] = key[i] & (HB_W'(i) < hb);
      end
      wide = {{DIR_W{1'b0}}, h};
      if (hb >= HB_W'(MAX_DEPTH)) begin
         wide = wide >> (hb - HB_W'(MAX_DEPTH));
      end else begin
         wide = wide << (HB_W'(MAX_DEPTH) - hb);
      end
      return wide[DIR_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/ehi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ehi_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire ehi_pkg::status_type status,
   output ehi_pkg::cmd_type        cmd
);
   import ehi_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIR_RD;
         end
         ST_DIR_RD:  state_in = ST_INFO_RD;
         ST_INFO_RD: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (status.fill_full || status.fill_append) state_in = ST_RESULT;
            else state_in = ST_KEY_ADDR;
         end
         ST_KEY_ADDR: state_in = ST_KEY_DATA;
         ST_KEY_DATA: begin
            if (status.keys_done) state_in = ST_SCAN;
            else state_in = ST_KEY_ADDR;
         end
         ST_SCAN: begin
            if (status.scan_ovf) state_in = ST_RESULT;
            else if (status.scan_hit) state_in = ST_SPLIT_DIR;
         end
         ST_SPLIT_DIR: begin
            if (status.dir_done) state_in = ST_SPLIT_INFO;
         end
         ST_SPLIT_INFO: begin
            if (status.split_last) state_in = ST_FINAL_INFO;
            else state_in = ST_SPLIT_DIR;
         end
         ST_FINAL_INFO: state_in = ST_KEY_WR;
         ST_KEY_WR: begin
            if (status.wr_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_DIR_RD:     cmd = '0;
         ST_INFO_RD:    cmd.info_rd = 1'b1;
         ST_DECIDE:     cmd.decide = 1'b1;
         ST_KEY_ADDR:   cmd = '0;
         ST_KEY_DATA:   cmd.key_cap = 1'b1;
         ST_SCAN:       cmd.scan = 1'b1;
         ST_SPLIT_DIR:  cmd.split_dir = 1'b1;
         ST_SPLIT_INFO: cmd.split_info = 1'b1;
         ST_FINAL_INFO: cmd.final_info = 1'b1;
         ST_KEY_WR:     cmd.key_wr = 1'b1;
         ST_RESULT:     cmd.result_ld = status.rsp_free;
         default:       cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> src/ehi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ehi_datapath #(
   parameter int BUCKET_SLOTS = ehi_pkg::BUCKET_SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ehi_pkg::cmd_type              cmd,
   output ehi_pkg::status_type                status,
   input  wire logic [ehi_pkg::KEY_WIDTH-1:0] req_key,
   input  wire logic                          csr_we,
   input  wire logic [ehi_pkg::HB_W-1:0]      csr_wdata,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [ehi_pkg::DIR_W-1:0]          rsp_index,
   output logic [ehi_pkg::DEPTH_W-1:0]        rsp_local_depth,
   output logic [ehi_pkg::DEPTH_W-1:0]        rsp_global_depth,
   output logic [ehi_pkg::DEPTH_W-1:0]        rsp_split_count,
   output logic                               rsp_overflow
);
   import ehi_pkg::*;

   localparam int SLOT_W    = $clog2(BUCKET_SLOTS);
   localparam int FILL_W    = $clog2(BUCKET_SLOTS + 1);
   localparam int INFO_W    = DEPTH_W + FILL_W;
   localparam int KEY_DEPTH = DIR_SIZE * BUCKET_SLOTS;
   localparam int KA_W      = $clog2(KEY_DEPTH);

   // memories: directory at full depth, bucket info {depth, fill}, bucket keys
   logic [DIR_W-1:0]     dir_mem  [DIR_SIZE];
   logic [INFO_W-1:0]    info_mem [DIR_SIZE];
   logic [KEY_WIDTH-1:0] key_mem  [KEY_DEPTH];

   logic [DIR_W-1:0]     dir_q;
   logic [INFO_W-1:0]    info_q;
   logic [KEY_WIDTH-1:0] key_q;

   logic [HB_W-1:0]      hb_ff;
   logic [DIR_W-1:0]     hf_ff;
   logic [KEY_WIDTH-1:0] key_ff [BUCKET_SLOTS];
   logic [DIR_W-1:0]     khf_ff [BUCKET_SLOTS];
   logic [DIR_W-1:0]     diff_ff;
   logic [DIR_W-1:0]     b_ff;
   logic [DEPTH_W-1:0]   d_ff;
   logic [DEPTH_W-1:0]   j_ff;
   logic [DEPTH_W-1:0]   k_ff;
   logic                 ovf_ff;
   logic [DIR_W-1:0]     c_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    cnt0_ff;
   logic [SLOT_W-1:0]    cnt1_ff;
   logic [DEPTH_W-1:0]   gd_ff;
   logic [USED_W-1:0]    used_ff;
   logic                 rsp_valid_ff;
   logic [DIR_W-1:0]     rsp_index_ff;
   logic [DEPTH_W-1:0]   rsp_ld_ff;
   logic [DEPTH_W-1:0]   rsp_gd_ff;
   logic [DEPTH_W-1:0]   rsp_sc_ff;
   logic                 rsp_ovf_ff;

   logic [FILL_W-1:0]    info_fill;
   logic [DEPTH_W-1:0]   info_depth;
   logic [DIR_W-1:0]     req_hash;
   logic [DIR_W-1:0]     kq_hash;
   logic [DJ_W-1:0]      dj;
   logic [DJ_W-1:0]      pos_w;
   logic [POS_W-1:0]     pos;
   logic [HB_W-1:0]      lim;
   logic [DIR_W:0]       blk;
   logic [DIR_W:0]       half;
   logic [DIR_W-1:0]     base;
   logic [DIR_W-1:0]     last;
   logic [DIR_W-1:0]     nb;
   logic                 s_bit;
   logic                 key_bit;
   logic [FILL_W-1:0]    c0;
   logic [FILL_W-1:0]    c1;
   logic [DEPTH_W-1:0]   depth_new;

   logic                 dir_we;
   logic [DIR_W-1:0]     dir_wa;
   logic [DIR_W-1:0]     dir_wd;
   logic                 info_we;
   logic [DIR_W-1:0]     info_wa;
   logic [INFO_W-1:0]    info_wd;
   logic                 key_we;
   logic [KA_W-1:0]      key_wa;
   logic [KEY_WIDTH-1:0] key_wd;
   logic [KA_W-1:0]      key_ra;

   function automatic logic bit_at(input logic [DIR_W-1:0] v, input logic [POS_W-1:0] p);
      bit_at = ({1'b0, p} < (POS_W + 1)'(DIR_W)) ? v[p] : 1'b0;
   endfunction

   assign info_fill  = info_q[FILL_W-1:0];
   assign info_depth = info_q[INFO_W-1:FILL_W];
   assign req_hash   = full_hash(req_key, hb_ff);
   assign kq_hash    = full_hash(key_q, hb_ff);

   // split position counted from the top of the full-depth index
   assign dj        = DJ_W'(d_ff) + DJ_W'(j_ff);
   assign pos_w     = DJ_W'(MAX_DEPTH - 1) - dj;
   assign pos       = pos_w[POS_W-1:0];
   assign lim       = (hb_ff < HB_W'(MAX_DEPTH)) ? hb_ff : HB_W'(MAX_DEPTH);
   assign depth_new = DEPTH_W'(dj + DJ_W'(1));

   // upper half of the aligned directory block owned by the bucket
   assign blk   = (DIR_W + 1)'(1) << (DJ_W'(MAX_DEPTH) - dj);
   assign half  = blk >> 1;
   assign base  = (hf_ff & ~DIR_W'(blk - (DIR_W + 1)'(1))) | DIR_W'(half);
   assign last  = DIR_W'(half - (DIR_W + 1)'(1));
   assign nb    = used_ff[DIR_W-1:0];
   assign s_bit = bit_at(hf_ff, pos);
   assign key_bit = bit_at(khf_ff[slot_ff], pos);

   always_comb begin
      c0 = '0;
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         if (!bit_at(khf_ff[i], pos)) c0 = c0 + FILL_W'(1);
      end
      c1 = FILL_W'(BUCKET_SLOTS) - c0;
   end

   assign key_ra = KA_W'(b_ff) * KA_W'(BUCKET_SLOTS) + KA_W'(slot_ff);

   always_comb begin
      dir_we  = 1'b0;
      dir_wa  = c_ff;
      dir_wd  = '0;
      info_we = 1'b0;
      info_wa = c_ff;
      info_wd = '0;
      key_we  = 1'b0;
      key_wa  = KA_W'(b_ff) * KA_W'(BUCKET_SLOTS) + KA_W'(info_fill);
      key_wd  = key_ff[BUCKET_SLOTS-1];
      if (cmd.clear_wr) begin
         dir_we  = 1'b1;
         info_we = 1'b1;
      end
      if (cmd.decide && info_fill < FILL_W'(BUCKET_SLOTS - 1)) begin
         key_we  = 1'b1;
         info_we = 1'b1;
         info_wa = b_ff;
         info_wd = {info_depth, info_fill + FILL_W'(1)};
      end
      if (cmd.split_dir) begin
         dir_we = 1'b1;
         dir_wa = base | c_ff;
         dir_wd = nb;
      end
      if (cmd.split_info) begin
         info_we = 1'b1;
         if (status.split_last) begin
            info_wa = b_ff;
            info_wd = {depth_new, c0};
         end else begin
            // the side that lost every key
            info_wa = s_bit ? b_ff : nb;
            info_wd = {depth_new, FILL_W'(0)};
         end
      end
      if (cmd.final_info) begin
         info_we = 1'b1;
         info_wa = nb;
         info_wd = {depth_new, c1};
      end
      if (cmd.key_wr) begin
         key_we = 1'b1;
         key_wa = KA_W'(key_bit ? nb : b_ff) * KA_W'(BUCKET_SLOTS)
                + KA_W'(key_bit ? cnt1_ff : cnt0_ff);
         key_wd = key_ff[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_wa] <= dir_wd;
      dir_q <= dir_mem[hf_ff];
   end

   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_wa] <= info_wd;
      info_q <= info_mem[dir_q];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= key_wd;
      key_q <= key_mem[key_ra];
   end

   always_comb begin
      status.clear_done  = c_ff == DIR_W'(DIR_SIZE - 1);
      status.fill_full   = info_fill >= FILL_W'(BUCKET_SLOTS);
      status.fill_append = info_fill < FILL_W'(BUCKET_SLOTS - 1);
      status.keys_done   = slot_ff == SLOT_W'(BUCKET_SLOTS - 2);
      status.scan_ovf    = (HB_W'(dj) + HB_W'(1) > lim)
                        || (used_ff + USED_W'(j_ff) >= USED_W'(DIR_SIZE));
      status.scan_hit    = bit_at(diff_ff, pos);
      status.dir_done    = c_ff == last;
      status.split_last  = j_ff == k_ff - DEPTH_W'(1);
      status.wr_done     = slot_ff == SLOT_W'(BUCKET_SLOTS - 1);
      status.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_ff        <= HB_RESET;
         gd_ff        <= '0;
         used_ff      <= USED_W'(1);
         c_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) hb_ff <= csr_wdata;
         if (cmd.clear_wr) c_ff <= c_ff + DIR_W'(1);
         if (cmd.accept) begin
            key_ff[BUCKET_SLOTS-1] <= req_key;
            khf_ff[BUCKET_SLOTS-1] <= req_hash;
            hf_ff                  <= req_hash;
            k_ff                   <= '0;
            ovf_ff                 <= 1'b0;
            diff_ff                <= '0;
            slot_ff                <= '0;
            j_ff                   <= '0;
         end
         if (cmd.info_rd) b_ff <= dir_q;
         if (cmd.decide) begin
            d_ff <= info_depth;
            if (status.fill_full) ovf_ff <= 1'b1;
         end
         if (cmd.key_cap) begin
            key_ff[slot_ff] <= key_q;
            khf_ff[slot_ff] <= kq_hash;
            diff_ff         <= diff_ff | (kq_hash ^ hf_ff);
            slot_ff         <= slot_ff + SLOT_W'(1);
         end
         if (cmd.scan) begin
            if (status.scan_ovf) begin
               ovf_ff <= 1'b1;
            end else if (status.scan_hit) begin
               k_ff <= j_ff + DEPTH_W'(1);
               j_ff <= '0;
               c_ff <= '0;
            end else begin
               j_ff <= j_ff + DEPTH_W'(1);
            end
         end
         if (cmd.split_dir) c_ff <= status.dir_done ? '0 : c_ff + DIR_W'(1);
         if (cmd.split_info) begin
            if (depth_new > gd_ff) gd_ff <= depth_new;
            if (!status.split_last) begin
               b_ff    <= s_bit ? nb : b_ff;
               used_ff <= used_ff + USED_W'(1);
               j_ff    <= j_ff + DEPTH_W'(1);
            end
         end
         if (cmd.final_info) begin
            slot_ff <= '0;
            cnt0_ff <= '0;
            cnt1_ff <= '0;
         end
         if (cmd.key_wr) begin
            if (key_bit) cnt1_ff <= cnt1_ff + SLOT_W'(1);
            else cnt0_ff <= cnt0_ff + SLOT_W'(1);
            slot_ff <= slot_ff + SLOT_W'(1);
            if (status.wr_done) used_ff <= used_ff + USED_W'(1);
         end
         if (cmd.result_ld) begin
            rsp_valid_ff <= 1'b1;
            rsp_index_ff <= DIR_W'(hf_ff >> (DJ_W'(MAX_DEPTH) - DJ_W'(gd_ff)));
            rsp_ld_ff    <= ovf_ff ? d_ff : d_ff + k_ff;
            rsp_gd_ff    <= gd_ff;
            rsp_sc_ff    <= ovf_ff ? '0 : k_ff;
            rsp_ovf_ff   <= ovf_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_index        = rsp_index_ff;
   assign rsp_local_depth  = rsp_ld_ff;
   assign rsp_global_depth = rsp_gd_ff;
   assign rsp_split_count  = rsp_sc_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   `ASSERT_CLK(a_no_write_on_ovf, clock, reset, cmd.split_dir |-> !ovf_ff, "split after overflow")
   `ASSERT_CLK(a_depth_order, clock, reset, (cmd.result_ld && !ovf_ff) |-> (DJ_W'(d_ff) + DJ_W'(k_ff) <= DJ_W'(gd_ff)), "local depth above global depth")
   `ASSERT_CLK(a_used_step, clock, reset, (used_ff != $past(used_ff)) |-> (used_ff == $past(used_ff) + USED_W'(1)), "bucket count jumped")

endmodule

`default_nettype wire

>>> src/extendible_hash_insert_top.sv
// Extendible hash insert engine.
// req channel: one key per request, taken when req_tvalid and req_tready are high.
// rsp channel: one result per request: directory index, local depth, global depth,
//   split count and an overflow flag (key not stored, table left unchanged).
// csr port: csr_we writes csr_wdata into the hash width register (reset value 6).
// Steps: a key that fits in its bucket is written at the decide step, then its
// result is loaded. A key that fills its bucket first reads each stored key, scans
// the depth bits in turn, and per split rewrites each directory entry moved to the
// new bucket (2^(5-depth), up to 32) and then the bucket info; it then writes the
// new bucket's info and writes every key back. The longest insert is six splits
// from depth zero, where the directory rewrite takes most of the time.
// One request is in flight at a time; req_tready is high only when idle.
// After reset a pass over all 64 entries clears the directory and bucket info,
// during which no request is taken; csr writes are accepted throughout.
// The result sits in an output register; if rsp_tready is low the next request
// is still accepted and processed, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module extendible_hash_insert_top #(
   parameter int BUCKET_SLOTS = ehi_pkg::BUCKET_SLOTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [ehi_pkg::REQ_W-1:0] req_tdata,   // key
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // directory_index, local_depth, global_depth, split_count, overflow
   output logic [ehi_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire logic                      csr_we,
   input  wire logic [ehi_pkg::HB_W-1:0]  csr_wdata
);
   import ehi_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [DIR_W-1:0]    rsp_index;
   logic [DEPTH_W-1:0]  rsp_local_depth;
   logic [DEPTH_W-1:0]  rsp_global_depth;
   logic [DEPTH_W-1:0]  rsp_split_count;
   logic                rsp_overflow;

   ehi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ehi_datapath #(
      .BUCKET_SLOTS (BUCKET_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_key          (req_tdata[KEY_WIDTH-1:0]),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_index        (rsp_index),
      .rsp_local_depth  (rsp_local_depth),
      .rsp_global_depth (rsp_global_depth),
      .rsp_split_count  (rsp_split_count),
      .rsp_overflow     (rsp_overflow)
   );

   assign rsp_tdata = {rsp_overflow, rsp_split_count, rsp_global_depth,
                       rsp_local_depth, rsp_index};

endmodule

`default_nettype wire
